@@ sv/udprc_pkg.sv @@
// udprc_pkg: shared types and constants for the UDP receive checker.
// Used by every module of the block but udprc_fifo. Depends on nothing.
package udprc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT    = 2'd1;

    localparam logic [1:0] STATUS_ACCEPTED       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM_ERROR = 2'd1;
    localparam logic [1:0] STATUS_PORT_MISMATCH  = 2'd2;
    localparam logic [1:0] STATUS_LENGTH_ERROR   = 2'd3;

    localparam logic [15:0] HEADER_BYTES = 16'd8;
    localparam logic [15:0] PROTOCOL_UDP = 16'd17;
    localparam logic [15:0] POS_MAX      = 16'hffff;

    localparam int ADDEND_W = 19;

    localparam int UDPRC_MID_DEPTH = 4;
    localparam int UDPRC_OUT_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] source_address;
        logic        last_byte;
    } udprc_in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        end_of_datagram;
        logic [1:0]  status;
        logic [15:0] sender_port;
        logic [15:0] payload_length;
    } udprc_out_t;

    // One classified byte, handed from front to back.
    typedef struct packed {
        logic                first;
        logic [ADDEND_W-1:0] addend;
        logic                last;
        logic                len_err;
        logic                port_mismatch;
        logic                payload;
        logic [7:0]          data_byte;
        logic [15:0]         sender_port;
        logic [15:0]         payload_length;
    } udprc_op_t;

endpackage

@@ sv/udprc_fifo.sv @@
// udprc_fifo: small synchronous queue of register entries, generic payload type.
// Depends on nothing; DEPTH of 2 or more.
module udprc_fifo #(
    parameter int  DEPTH = 4,
    parameter type T     = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wr_data,
    output logic full,
    input  logic pop,
    output T     rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    T              mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/udprc_front.sv @@
// udprc_front: accepts datagram bytes, parses the UDP header and classifies each beat.
// Emits one udprc_op_t per beat with its checksum addend. Depends on udprc_pkg.
module udprc_front
    import udprc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  udprc_in_t   data_beat,
    input  logic [31:0] host_addr,
    input  logic [15:0] host_port,
    input  logic        op_full,
    output logic        op_push,
    output udprc_op_t   op_data
);

    localparam logic [15:0] POS_SRC_HI = 16'd0;
    localparam logic [15:0] POS_SRC_LO = 16'd1;
    localparam logic [15:0] POS_DST_HI = 16'd2;
    localparam logic [15:0] POS_DST_LO = 16'd3;
    localparam logic [15:0] POS_LEN_HI = 16'd4;
    localparam logic [15:0] POS_LEN_LO = 16'd5;
    localparam logic [15:0] MIN_BYTES  = 16'd6;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [7:0]  pend_reg, pend_next;
    logic        done_reg;

    logic [15:0]         pos, len_cur, src_cur, dst_cur;
    logic [7:0]          pend_cur, b;
    logic                counted, payload, len_err, accept;
    logic [16:0]         count;
    logic [15:0]         word_add, pad;
    logic [ADDEND_W-1:0] pseudo, addend;

    assign accept  = push && !op_full;
    assign op_push = accept;

    always_comb
    begin
        b        = data_beat.data_byte;
        // a closed datagram starts over with all state cleared
        pos      = done_reg ? '0 : pos_reg;
        len_cur  = done_reg ? '0 : len_reg;
        src_cur  = done_reg ? '0 : src_reg;
        dst_cur  = done_reg ? '0 : dst_reg;
        pend_cur = done_reg ? '0 : pend_reg;

        src_next = src_cur;
        dst_next = dst_cur;
        len_next = len_cur;
        unique case (pos)
            POS_SRC_HI: src_next = {b, 8'h00};
            POS_SRC_LO: src_next = {src_cur[15:8], b};
            POS_DST_HI: dst_next = {b, 8'h00};
            POS_DST_LO: dst_next = {dst_cur[15:8], b};
            POS_LEN_HI: len_next = {b, 8'h00};
            POS_LEN_LO: len_next = {len_cur[15:8], b};
            default:    ;
        endcase

        counted   = (pos < MIN_BYTES) || (pos < len_next);
        word_add  = (counted && pos[0]) ? {pend_cur, b} : '0;
        pend_next = (counted && !pos[0]) ? b : pend_cur;
        payload   = (pos >= HEADER_BYTES) && (pos < len_next);
        pos_next  = (pos != POS_MAX) ? pos + 16'd1 : pos;

        count   = {1'b0, pos} + 17'd1;
        len_err = (count < {1'b0, MIN_BYTES}) || (len_next < HEADER_BYTES)
                  || (count < {1'b0, len_next});
        // odd length: trailing byte padded with a zero low byte
        pad = (data_beat.last_byte && !len_err && len_next[0]) ? {pend_next, 8'h00} : '0;

        pseudo = ADDEND_W'(data_beat.source_address[31:16])
               + ADDEND_W'(data_beat.source_address[15:0])
               + ADDEND_W'(host_addr[31:16])
               + ADDEND_W'(host_addr[15:0])
               + ADDEND_W'(PROTOCOL_UDP);
        addend = ((pos == POS_SRC_HI) ? pseudo : '0)
               + ((pos == POS_LEN_LO) ? ADDEND_W'(len_next) : '0)
               + ADDEND_W'(word_add)
               + ADDEND_W'(pad);

        op_data.first          = (pos == POS_SRC_HI);
        op_data.addend         = addend;
        op_data.last           = data_beat.last_byte;
        op_data.len_err        = len_err;
        op_data.port_mismatch  = (dst_next != host_port);
        op_data.payload        = payload;
        op_data.data_byte      = b;
        op_data.sender_port    = src_next;
        op_data.payload_length = (len_next >= HEADER_BYTES) ? len_next - HEADER_BYTES : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            pend_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            pend_reg <= pend_next;
            done_reg <= data_beat.last_byte;
        end
    end

endmodule

@@ sv/udprc_back.sv @@
// udprc_back: runs the ones-complement sum over classified beats and forms results.
// Drives the result queue. Depends on udprc_pkg.
module udprc_back
    import udprc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_empty,
    input  udprc_op_t  op_data,
    output logic       op_pop,
    input  logic       out_full,
    output logic       out_push,
    output udprc_out_t out_data
);

    logic [15:0] acc_reg, acc_next;
    logic [15:0] base;
    logic [19:0] s;
    logic [16:0] t;
    logic        produce, go, chk_bad;

    always_comb
    begin
        produce = op_data.payload || op_data.last;
        go      = !op_empty && (!produce || !out_full);

        base     = op_data.first ? '0 : acc_reg;
        s        = 20'(base) + 20'(op_data.addend);
        t        = 17'(s[15:0]) + 17'(s[19:16]);
        acc_next = t[15:0] + 16'(t[16]);
        chk_bad  = (acc_next != 16'hffff) && (acc_next != 16'h0000);

        out_data.payload_byte    = op_data.payload ? op_data.data_byte : '0;
        out_data.payload_valid   = op_data.payload;
        out_data.end_of_datagram = op_data.last;
        out_data.sender_port     = op_data.last ? op_data.sender_port : '0;
        out_data.payload_length  = op_data.last ? op_data.payload_length : '0;
        priority if (!op_data.last)
            out_data.status = STATUS_ACCEPTED;
        else if (op_data.len_err)
            out_data.status = STATUS_LENGTH_ERROR;
        else if (chk_bad)
            out_data.status = STATUS_CHECKSUM_ERROR;
        else if (op_data.port_mismatch)
            out_data.status = STATUS_PORT_MISMATCH;
        else
            out_data.status = STATUS_ACCEPTED;
    end

    assign op_pop   = go;
    assign out_push = go && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (go)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ sv/udp_receive_checker.sv @@
// udp_receive_checker: top level; config registers, front, beat queue, back, result queue.
// Depends on udprc_pkg, udprc_fifo, udprc_front, udprc_back.
// A byte is registered in the beat queue, then in the result queue, before its result shows.
// Throughput: one byte per cycle while neither queue is full; add and fold are combinational.
// full rises when the beat queue (MID_DEPTH entries) is full; empty follows the result queue.
// Reset: rst_n low clears both queues, datagram state and the config registers to zero.
module udp_receive_checker
    import udprc_pkg::*;
#(
    parameter int MID_DEPTH = UDPRC_MID_DEPTH,
    parameter int OUT_DEPTH = UDPRC_OUT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  udprc_in_t              data_beat,
    output logic                   empty,
    input  logic                   pop,
    output udprc_out_t             result_beat,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0] host_addr_reg;
    logic [15:0] host_port_reg;

    logic       op_push, op_full, op_pop, op_empty;
    udprc_op_t  op_wr, op_rd;
    logic       out_push, out_full;
    udprc_out_t out_wr;

    assign cfg_ready = 1'b1;
    assign full      = op_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_addr_reg <= '0;
            host_port_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOCAL_ADDRESS: host_addr_reg <= cfg_data[31:0];
                CFG_LOCAL_PORT:    host_port_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    udprc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_beat (data_beat),
        .host_addr (host_addr_reg),
        .host_port (host_port_reg),
        .op_full   (op_full),
        .op_push   (op_push),
        .op_data   (op_wr)
    );

    udprc_fifo #(
        .DEPTH (MID_DEPTH),
        .T     (udprc_op_t)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_push),
        .wr_data (op_wr),
        .full    (op_full),
        .pop     (op_pop),
        .rd_data (op_rd),
        .empty   (op_empty)
    );

    udprc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op_data  (op_rd),
        .op_pop   (op_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_wr)
    );

    udprc_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (udprc_out_t)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_wr),
        .full    (out_full),
        .pop     (pop),
        .rd_data (result_beat),
        .empty   (empty)
    );

endmodule

@@ sv/udprc_checker.sv @@
// udprc_checker: port-level assertions for udp_receive_checker, plus its bind.
// Depends on udprc_pkg and the top level's port list.
module udprc_checker
    import udprc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input udprc_out_t result_beat
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_result_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_beat.payload_valid || result_beat.end_of_datagram))
        else $error("result beat with neither payload nor verdict");

    a_verdict_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_beat.end_of_datagram) |->
            (result_beat.status == STATUS_ACCEPTED && result_beat.sender_port == '0
             && result_beat.payload_length == '0))
        else $error("verdict fields set on a payload-only beat");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_beat.payload_valid) |-> (result_beat.payload_byte == '0))
        else $error("payload byte set without payload_valid");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_beat)))
        else $error("stalled result beat changed");

endmodule

bind udp_receive_checker udprc_checker u_udprc_checker (.*);
